// File: sv/assert_macros.svh
// Assertion macros used by the RTL of the touch serial command framer.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define TSC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("tsc assertion failed");

// The expression must never be true outside reset.
`define TSC_ASSERT_NEVER(lbl, expr) \
    `TSC_ASSERT(lbl, !(expr))

`endif

// File: sv/tsc_pkg.sv
// Package for the touch serial command framer: transaction structs,
// protocol characters, command words and packet constants. No dependencies.
`timescale 1ns / 1ps

package tsc_pkg;

    // Default command buffer depth
    localparam int CMD_DEPTH_DEF = 16;

    // Touch packet layout
    localparam int MASK_W     = 34;
    localparam int SLICE_W    = 5;
    localparam int NUM_SLICES = 7;

    // Framing and packet characters
    localparam logic [7:0] C_OPEN_BRACE  = 8'h7B;
    localparam logic [7:0] C_CLOSE_BRACE = 8'h7D;
    localparam logic [7:0] C_OPEN_PAREN  = 8'h28;
    localparam logic [7:0] C_CLOSE_PAREN = 8'h29;

    // Four-character commands, first character in the top byte
    localparam int          CMD_WORD_LEN = 4;
    localparam logic [31:0] W_HALT = 32'h48414C54;
    localparam logic [31:0] W_RSET = 32'h52534554;
    localparam logic [31:0] W_STAT = 32'h53544154;
    localparam logic [31:0] W_DBON = 32'h44424F4E;
    localparam logic [31:0] W_DBOF = 32'h44424F46;

    // Input transaction
    typedef struct packed {
        logic              req_type;
        logic [7:0]        rx_byte;
        logic [MASK_W-1:0] touch_mask;
    } t_in_item;

    // Output transaction
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_byte;
        logic       debug_on;
    } t_out_item;

    // Command buffer write control
    typedef struct packed {
        logic       en;
        logic       head;
        logic [7:0] data;
    } t_buf_wr;

endpackage

// File: sv/touch_serial_command_framer.sv
// Top level of the touch serial command framer: host byte deframer,
// command decoder and byte-serial packet sequencer. Uses tsc_pkg, tsc_cmd_buf.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage
//   Input channel (i_in_valid / o_in_stall / i_in_item) carries either a host
//   byte (req_type 0) or a 34-bit touch mask sample (req_type 1).
//   Output channel (o_out_valid / i_out_stall / o_out_item) carries one
//   byte per transaction; last_byte marks the closing ')' of a packet.
//   A host byte that only updates framing state leaves the block idle.
//   A touch packet is 9 bytes, an echo 2 + length bytes (up to CMD_DEPTH + 2).
//   The sequencer emits one byte a cycle through the output register while the
//   receiver does not stall; the next input is taken once the closing byte
//   has been loaded into the register.
//   The 5-bit slices come from a single shift register stepped once per
//   byte; echo bytes come from the command memory read one address a cycle
//   while not stalled. When the receiver stalls, the sequencer and output hold.
//   Reset leaves the block halted (no touch packets until STAT), debug off,
//   outside any frame, with an empty output register.

module touch_serial_command_framer
    import tsc_pkg::*;
#(
    parameter int CMD_DEPTH = CMD_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int ADDR_W = $clog2(CMD_DEPTH);
    localparam int LEN_W  = $clog2(CMD_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_OPEN  = 4'b0010,
        S_DATA  = 4'b0100,
        S_CLOSE = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic              r_halted, n_halted;
    logic [MASK_W-1:0] r_mask, n_mask;
    logic [MASK_W-1:0] r_shift, n_shift;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [LEN_W-1:0]  r_cnt, n_cnt;
    logic [ADDR_W-1:0] r_ptr, n_ptr;
    logic              r_in_frame, n_in_frame;
    logic              r_debug, n_debug;
    logic              r_is_touch, n_is_touch;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    t_buf_wr     buf_wr;
    logic [7:0]  rd_data;
    logic [31:0] head_word;
    logic        in_accept;
    logic        slot_free;
    logic        is_word;

    // Command memory
    tsc_cmd_buf #(
        .CMD_DEPTH (CMD_DEPTH)
    ) u_cmd_buf (
        .i_clk       (i_clk),
        .i_wr        (buf_wr),
        .i_wr_addr   (r_len[ADDR_W-1:0]),
        .i_rd_addr   (n_ptr),
        .o_rd_data   (rd_data),
        .o_head_word (head_word)
    );

    // Handshake
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign slot_free   = !r_out_valid || !i_out_stall;
    assign is_word     = (r_len == LEN_W'(CMD_WORD_LEN));
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Deframer, decoder and packet sequencer
    always_comb begin
        n_state     = r_state;
        n_halted    = r_halted;
        n_mask      = r_mask;
        n_shift     = r_shift;
        n_len       = r_len;
        n_cnt       = r_cnt;
        n_ptr       = r_ptr;
        n_in_frame  = r_in_frame;
        n_debug     = r_debug;
        n_is_touch  = r_is_touch;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        buf_wr      = '{en: 1'b0, head: 1'b0, data: i_in_item.rx_byte};

        case (r_state)
            S_IDLE: begin
                n_ptr = '0;
                if (in_accept) begin
                    if (i_in_item.req_type) begin
                        n_mask = i_in_item.touch_mask;
                        if (!r_halted) begin
                            n_shift    = i_in_item.touch_mask;
                            n_cnt      = LEN_W'(NUM_SLICES);
                            n_is_touch = 1'b1;
                            n_state    = S_OPEN;
                        end
                    end else if (i_in_item.rx_byte == C_OPEN_BRACE) begin
                        n_in_frame = 1'b1;
                        n_len      = '0;
                    end else if (i_in_item.rx_byte == C_CLOSE_BRACE) begin
                        if (r_in_frame) begin
                            n_in_frame = 1'b0;
                            if (is_word && (head_word == W_HALT || head_word == W_RSET)) begin
                                n_halted = 1'b1;
                            end else if (is_word && head_word == W_STAT) begin
                                n_halted   = 1'b0;
                                n_shift    = r_mask;
                                n_cnt      = LEN_W'(NUM_SLICES);
                                n_is_touch = 1'b1;
                                n_state    = S_OPEN;
                            end else if (is_word && head_word == W_DBON) begin
                                n_debug = 1'b1;
                            end else if (is_word && head_word == W_DBOF) begin
                                n_debug = 1'b0;
                            end else begin
                                n_cnt      = r_len;
                                n_is_touch = 1'b0;
                                n_state    = S_OPEN;
                            end
                        end
                    end else if (r_in_frame) begin
                        // Data byte: store, or abort the frame on overflow
                        if (r_len < LEN_W'(CMD_DEPTH)) begin
                            buf_wr.en   = 1'b1;
                            buf_wr.head = (r_len < LEN_W'(CMD_WORD_LEN));
                            n_len       = r_len + LEN_W'(1);
                        end else begin
                            n_in_frame = 1'b0;
                        end
                    end
                end
            end

            S_OPEN: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{tx_byte: C_OPEN_PAREN, last_byte: 1'b0,
                                    debug_on: r_debug};
                    n_state     = (r_cnt == '0) ? S_CLOSE : S_DATA;
                end
            end

            S_DATA: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out.last_byte = 1'b0;
                    n_out.debug_on  = r_debug;
                    if (r_is_touch) begin
                        n_out.tx_byte = {{(8 - SLICE_W){1'b0}}, r_shift[SLICE_W-1:0]};
                        n_shift       = r_shift >> SLICE_W;
                    end else begin
                        n_out.tx_byte = rd_data;
                        if (r_ptr != ADDR_W'(CMD_DEPTH - 1)) begin
                            n_ptr = r_ptr + ADDR_W'(1);
                        end
                    end
                    n_cnt = r_cnt - LEN_W'(1);
                    if (r_cnt == LEN_W'(1)) begin
                        n_state = S_CLOSE;
                    end
                end
            end

            S_CLOSE: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{tx_byte: C_CLOSE_PAREN, last_byte: 1'b1,
                                    debug_on: r_debug};
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_halted    <= 1'b1;
            r_mask      <= '0;
            r_len       <= '0;
            r_in_frame  <= 1'b0;
            r_debug     <= 1'b0;
            r_out_valid <= 1'b0;
            r_ptr       <= '0;
        end else begin
            r_state     <= n_state;
            r_halted    <= n_halted;
            r_mask      <= n_mask;
            r_len       <= n_len;
            r_in_frame  <= n_in_frame;
            r_debug     <= n_debug;
            r_out_valid <= n_out_valid;
            r_ptr       <= n_ptr;
        end
    end

    // Payload and sequencing data
    always_ff @(posedge i_clk) begin
        r_shift    <= n_shift;
        r_cnt      <= n_cnt;
        r_is_touch <= n_is_touch;
        r_out      <= n_out;
    end

    // Data state always has bytes left to send
    `TSC_ASSERT(a_data_cnt, (r_state == S_DATA) |-> (r_cnt != '0))
    // Frame length never passes the buffer depth
    `TSC_ASSERT_NEVER(a_len_range, r_len > LEN_W'(CMD_DEPTH))
    // A touch sample while halted starts no packet
    `TSC_ASSERT(a_halt_quiet,
        (in_accept && i_in_item.req_type && r_halted) |=> (r_state == S_IDLE))
    // The closing byte is the only one marked last
    `TSC_ASSERT(a_last_close,
        (r_out_valid && r_out.last_byte) |-> (r_out.tx_byte == C_CLOSE_PAREN))

endmodule

// File: sv/tsc_cmd_buf.sv
// Command byte buffer: memory with registered read for the echo stream,
// plus the first four bytes of the frame held for command decoding. Uses tsc_pkg.
`timescale 1ns / 1ps

module tsc_cmd_buf
    import tsc_pkg::*;
#(
    parameter int CMD_DEPTH = CMD_DEPTH_DEF,
    localparam int ADDR_W   = $clog2(CMD_DEPTH)
) (
    input  logic              i_clk,
    input  t_buf_wr           i_wr,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [7:0]        o_rd_data,
    output logic [31:0]       o_head_word
);

    logic [7:0] r_mem [CMD_DEPTH];
    logic [7:0] r_rd_data;
    logic [7:0] r_head [CMD_WORD_LEN];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr_addr] <= i_wr.data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    // Head bytes for the four-character commands
    always_ff @(posedge i_clk) begin
        if (i_wr.en && i_wr.head) begin
            r_head[i_wr_addr[1:0]] <= i_wr.data;
        end
    end

    assign o_rd_data   = r_rd_data;
    assign o_head_word = {r_head[0], r_head[1], r_head[2], r_head[3]};

endmodule

// File: dv/tb_touch_serial_command_framer.sv
// Self-checking testbench for touch_serial_command_framer: directed vectors, then
// random host byte and touch mask traffic checked against a behavioural predictor.
// Depends on tsc_pkg and the framer RTL only.
`timescale 1ns / 1ps

module tb_touch_serial_command_framer
    import tsc_pkg::*;
();

    localparam int RAND_ITEMS     = 480;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    // 12 ns clock
    always #6 i_clk = ~i_clk;

    touch_serial_command_framer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // Predictor state, starts at its reset values
    logic              lnk_halted   = 1'b1;
    logic [MASK_W-1:0] lnk_mask     = '0;
    logic [7:0]        lnk_cmd [CMD_DEPTH_DEF];
    int                lnk_len      = 0;
    logic              lnk_in_frame = 1'b0;
    logic              lnk_debug    = 1'b0;

    t_out_item step_bytes[$];   // bytes caused by the latest input transaction
    t_out_item tx_expect_q[$];  // bytes still owed by the block
    t_out_item next_tx;

    int send_gap_pct = 17;
    int stall_pct    = 64;
    int n_errors     = 0;
    int rand_sent    = 0;
    int idle_cycles  = 0;

    // Directed vectors; typed rows carry their expected bytes
    typedef struct {
        t_in_item  item;
        bit        typed;
        int        n_typed;
        t_out_item res0;
        t_out_item res1;
    } t_vec_row;

    t_vec_row vec_rows[$];

    // ---------------------------------------------------------------- predictor

    function automatic void put_tx(logic [7:0] b, logic last);
        t_out_item r;
        r.tx_byte   = b;
        r.last_byte = last;
        r.debug_on  = lnk_debug;
        step_bytes.push_back(r);
    endfunction

    // '(' + seven 5-bit slices, low bits first + ')'
    function automatic void put_touch_packet();
        put_tx(C_OPEN_PAREN, 1'b0);
        for (int s = 0; s < NUM_SLICES; s++)
            put_tx(8'((lnk_mask >> (SLICE_W * s)) & 34'h1F), 1'b0);
        put_tx(C_CLOSE_PAREN, 1'b1);
    endfunction

    function automatic void run_command();
        logic [31:0] word;
        logic        is4;
        word = {lnk_cmd[0], lnk_cmd[1], lnk_cmd[2], lnk_cmd[3]};
        is4  = (lnk_len == CMD_WORD_LEN);
        if (is4 && (word == W_HALT || word == W_RSET)) begin
            lnk_halted = 1'b1;
        end else if (is4 && word == W_STAT) begin
            lnk_halted = 1'b0;
            put_touch_packet();
        end else if (is4 && word == W_DBON) begin
            lnk_debug = 1'b1;
        end else if (is4 && word == W_DBOF) begin
            lnk_debug = 1'b0;
        end else begin
            // echo as (command)
            put_tx(C_OPEN_PAREN, 1'b0);
            for (int i = 0; i < lnk_len; i++)
                put_tx(lnk_cmd[i], 1'b0);
            put_tx(C_CLOSE_PAREN, 1'b1);
        end
    endfunction

    function automatic void predict_link(t_in_item it);
        step_bytes.delete();
        if (it.req_type) begin
            lnk_mask = it.touch_mask;
            if (!lnk_halted)
                put_touch_packet();
        end else if (it.rx_byte == C_OPEN_BRACE) begin
            // a new frame discards any partial one
            lnk_in_frame = 1'b1;
            lnk_len      = 0;
        end else if (it.rx_byte == C_CLOSE_BRACE) begin
            if (lnk_in_frame) begin
                lnk_in_frame = 1'b0;
                run_command();
            end
        end else if (lnk_in_frame) begin
            if (lnk_len < CMD_DEPTH_DEF) begin
                lnk_cmd[lnk_len] = it.rx_byte;
                lnk_len++;
            end else begin
                lnk_in_frame = 1'b0;   // overflow aborts the frame
            end
        end
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic t_in_item host_item(logic [7:0] b);
        t_in_item it;
        it.req_type   = 1'b0;
        it.rx_byte    = b;
        it.touch_mask = MASK_W'({$urandom, $urandom});
        return it;
    endfunction

    function automatic t_in_item touch_item(logic [MASK_W-1:0] m);
        t_in_item it;
        it.req_type   = 1'b1;
        it.rx_byte    = 8'($urandom_range(0, 255));
        it.touch_mask = m;
        return it;
    endfunction

    // any byte except the framing braces
    function automatic logic [7:0] rand_data_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == C_OPEN_BRACE || b == C_CLOSE_BRACE);
        return b;
    endfunction

    function automatic void add_host(logic [7:0] b, bit typed = 1'b0, int n = 0,
                                     t_out_item r0 = '0, t_out_item r1 = '0);
        t_vec_row row;
        row.item    = host_item(b);
        row.typed   = typed;
        row.n_typed = n;
        row.res0    = r0;
        row.res1    = r1;
        vec_rows.push_back(row);
    endfunction

    function automatic void add_touch(logic [MASK_W-1:0] m, bit typed = 1'b0);
        t_vec_row row;
        row.item    = touch_item(m);
        row.typed   = typed;
        row.n_typed = 0;
        row.res0    = '0;
        row.res1    = '0;
        vec_rows.push_back(row);
    endfunction

    function automatic void add_frame(string s);
        add_host(C_OPEN_BRACE);
        for (int i = 0; i < s.len(); i++)
            add_host(8'(s[i]));
        add_host(C_CLOSE_BRACE);
    endfunction

    // Drive one input transaction and hold it until taken
    task automatic send_item(input t_in_item it, input bit use_pred = 1'b1);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_gap_pct)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        predict_link(it);
        if (use_pred)
            foreach (step_bytes[k]) tx_expect_q.push_back(step_bytes[k]);
    endtask

    task automatic send_host(input logic [7:0] b);
        send_item(host_item(b));
        rand_sent++;
    endtask

    // ---------------------------------------------------------------- receiver side

    always @(posedge i_clk)
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            n_errors++;
        end
    endfunction

    // Output transactions against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (tx_expect_q.size() == 0) begin
                $display("%0t: unexpected output: expected none, actual %0h/%b/%b", $time,
                         o_out_item.tx_byte, o_out_item.last_byte, o_out_item.debug_on);
                n_errors++;
            end else begin
                next_tx = tx_expect_q.pop_front();
                check_field("tx_byte", next_tx.tx_byte, o_out_item.tx_byte);
                check_field("last_byte", 8'(next_tx.last_byte), 8'(o_out_item.last_byte));
                check_field("debug_on", 8'(next_tx.debug_on), 8'(o_out_item.debug_on));
            end
        end
    end

    // ---------------------------------------------------------------- watchdog

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);
        $display("Simulation FAILED");
        $finish;
    end

    // ---------------------------------------------------------------- main sequence

    initial begin
        int          kind;
        int          len;
        logic [31:0] word;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: halted after reset, stray bytes, empty command
        add_touch({MASK_W{1'b1}}, 1'b1);
        add_host(C_CLOSE_BRACE, 1'b1);
        add_host(8'hFF, 1'b1);
        add_host(8'h00, 1'b1);
        add_host(C_OPEN_BRACE);
        add_host(C_CLOSE_BRACE, 1'b1, 2,
                 '{tx_byte: C_OPEN_PAREN, last_byte: 1'b0, debug_on: 1'b0},
                 '{tx_byte: C_CLOSE_PAREN, last_byte: 1'b1, debug_on: 1'b0});
        // resume reporting, then all-zero and alternating touch masks with debug off and on
        add_frame("STAT");
        add_touch('0);
        add_frame("DBON");
        add_touch(34'h2AAAAAAAA);
        // nested open brace restarts the frame; RSET halts again
        add_host(C_OPEN_BRACE);
        add_frame("RSET");
        add_touch(34'h155555555, 1'b1);

        foreach (vec_rows[r]) begin
            send_item(vec_rows[r].item, !vec_rows[r].typed);
            if (vec_rows[r].typed && vec_rows[r].n_typed > 0)
                tx_expect_q.push_back(vec_rows[r].res0);
            if (vec_rows[r].typed && vec_rows[r].n_typed > 1)
                tx_expect_q.push_back(vec_rows[r].res1);
        end

        // Random traffic: complete frames, touch samples, frames left open and noise
        while (rand_sent < RAND_ITEMS) begin
            if (rand_sent >= 2 * RAND_ITEMS / 3) begin
                send_gap_pct = 0;
                stall_pct    = 0;
            end else if (rand_sent >= RAND_ITEMS / 3) begin
                send_gap_pct = 64;
                stall_pct    = 17;
            end
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
                send_host(C_OPEN_BRACE);
                if ($urandom_range(0, 2) == 0) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: word = W_STAT;
                        4:          word = W_HALT;
                        5:          word = W_RSET;
                        6, 7:       word = W_DBON;
                        default:    word = W_DBOF;
                    endcase
                    for (int i = CMD_WORD_LEN - 1; i >= 0; i--)
                        send_host(word[8 * i +: 8]);
                    // five-byte near miss
                    if ($urandom_range(0, 9) == 0)
                        send_host(rand_data_byte());
                end else begin
                    kind = $urandom_range(0, 99);
                    if (kind < 25)
                        len = CMD_DEPTH_DEF;
                    else if (kind < 35)
                        len = $urandom_range(CMD_DEPTH_DEF + 1, CMD_DEPTH_DEF + 3);
                    else
                        len = $urandom_range(0, CMD_DEPTH_DEF - 1);
                    repeat (len) send_host(rand_data_byte());
                end
                send_host(C_CLOSE_BRACE);
            end else if (kind < 70) begin
                send_item(touch_item(MASK_W'({$urandom, $urandom})));
                rand_sent++;
            end else if (kind < 85) begin
                // frame left open
                send_host(C_OPEN_BRACE);
                repeat ($urandom_range(0, 5)) send_host(rand_data_byte());
            end else begin
                repeat ($urandom_range(1, 3)) send_host(8'($urandom_range(0, 255)));
            end
        end
        i_in_valid <= 1'b0;

        // Drain outstanding bytes, then watch for strays
        while (tx_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+sv
sv/tsc_pkg.sv
sv/tsc_cmd_buf.sv
sv/touch_serial_command_framer.sv
dv/tb_touch_serial_command_framer.sv
